[rtl/sspq_pkg.sv]
package sspq_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int KEY_W     = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELMIN = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_CMP
    } state_t;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } cell_ctrl_t;

endpackage

[rtl/sorted_set_priority_queue.sv]
// Channel  Direction  Beat contents
// s_       input      tuser: mode [1:0]; tdata: key [31:0]
// m_       output     tdata: success [0], status [2:1], min_value [34:3], zero [39:35]
//
// Each item has a compare step, in which every cell compares its key with the
// item's key, then an update step: the cells shift and the result register is loaded.
// The update step waits while the result register still holds an untaken beat.
// Reset empties the set at once; stored keys are not cleared.
module sorted_set_priority_queue
    import sspq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // key
    input  logic [S_TUSER_W-1:0] s_tuser,  // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // success, status, min_value, zero fill
);

    localparam int CW = $clog2(CAPACITY + 1);

    state_t                  state_reg, state_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic signed [KEY_W-1:0] op_key_reg, op_key_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg, m_data_next;

    cell_ctrl_t              ctrl;
    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]     cell_ge;
    logic [CAPACITY-1:0]     cell_eq;
    logic [CAPACITY-1:0]     occupied;

    logic                    hit, full, empty, out_free;
    logic                    success;
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] min_value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [KEY_W-1:0] left_key;
        logic                    left_ge;
        logic signed [KEY_W-1:0] right_key;

        if (i == 0) begin : g_first
            assign left_key = op_key_reg;
            assign left_ge  = 1'b0;
        end else begin : g_mid
            assign left_key = cell_key[i-1];
            assign left_ge  = cell_ge[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_key = cell_key[i];
        end else begin : g_notlast
            assign right_key = cell_key[i+1];
        end

        assign occupied[i] = (CW'(i) < count_reg);

        sspq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (occupied[i]),
            .op_key    (op_key_next),
            .left_key  (left_key),
            .left_ge   (left_ge),
            .right_key (right_key),
            .key_o     (cell_key[i]),
            .ge_o      (cell_ge[i]),
            .eq_o      (cell_eq[i])
        );
    end

    assign hit      = |cell_eq;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        op_key_next  = op_key_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        ctrl         = '0;
        success      = 1'b0;
        status       = STAT_MISS;
        min_value    = '0;
        s_tready     = (state_reg == S_IDLE);

        unique case (mode_reg)
            MODE_SEARCH: begin
                success = hit;
                status  = hit ? STAT_OK : STAT_MISS;
            end
            MODE_INSERT: begin
                if (hit) begin
                    status = STAT_MISS;
                end else if (full) begin
                    status = STAT_FULL;
                end else begin
                    success = 1'b1;
                    status  = STAT_OK;
                end
            end
            MODE_DELMIN: begin
                if (empty) begin
                    status = STAT_EMPTY;
                end else begin
                    success   = 1'b1;
                    status    = STAT_OK;
                    min_value = cell_key[0];
                end
            end
            default: begin
                status = STAT_MISS;
            end
        endcase

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next   = s_tuser[MODE_W-1:0];
                    op_key_next = s_tdata[KEY_W-1:0];
                    ctrl.cmp    = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(M_TDATA_W - KEY_W - STATUS_W - 1)'(0),
                                    min_value, status, success};
                    if (success && mode_reg == MODE_INSERT) begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else if (success && mode_reg == MODE_DELMIN) begin
                        ctrl.del   = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg   <= mode_next;
        op_key_reg <= op_key_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[rtl/sspq_cell.sv]
module sspq_cell
    import sspq_pkg::*;
(
    input  logic                    aclk,
    input  cell_ctrl_t              ctrl,
    input  logic                    occupied,
    input  logic signed [KEY_W-1:0] op_key,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic                    left_ge,
    input  logic signed [KEY_W-1:0] right_key,
    output logic signed [KEY_W-1:0] key_o,
    output logic                    ge_o,
    output logic                    eq_o
);

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic                    ge_reg, ge_next;
    logic                    eq_reg, eq_next;

    always_comb begin
        ge_next  = ge_reg;
        eq_next  = eq_reg;
        key_next = key_reg;
        if (ctrl.cmp) begin
            ge_next = !occupied || (key_reg >= op_key);
            eq_next = occupied && (key_reg == op_key);
        end
        if (ctrl.ins && ge_reg) begin
            key_next = left_ge ? left_key : op_key;
        end else if (ctrl.del) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        ge_reg  <= ge_next;
        eq_reg  <= eq_next;
    end

    assign key_o = key_reg;
    assign ge_o  = ge_reg;
    assign eq_o  = eq_reg;

endmodule
